/* sv/prpz_pkg.sv */
// Shared constants, types and helpers for the point rotate / project / depth-buffer block.
// No dependencies; every other file refers to this package by scoped names.
package prpz_pkg;

    localparam int SCREEN_WIDTH     = 100;
    localparam int SCREEN_HEIGHT    = 50;
    localparam int PROJECTION_SCALE = 40;
    localparam int CELLS            = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CELL_W           = $clog2(CELLS);
    localparam int HALF_W           = SCREEN_WIDTH / 2;
    localparam int HALF_H           = SCREEN_HEIGHT / 2;

    localparam logic [7:0] SPACE_GLYPH = 8'd32;

    localparam logic [2:0] REG_SIN_A  = 3'd0;
    localparam logic [2:0] REG_COS_A  = 3'd1;
    localparam logic [2:0] REG_SIN_B  = 3'd2;
    localparam logic [2:0] REG_COS_B  = 3'd3;
    localparam logic [2:0] REG_SIN_C  = 3'd4;
    localparam logic [2:0] REG_COS_C  = 3'd5;
    localparam logic [2:0] REG_CAM    = 3'd6;
    localparam logic [2:0] REG_SHIFT  = 3'd7;

    localparam logic CMD_PLOT = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic signed [15:0] sa;
        logic signed [15:0] ca;
        logic signed [15:0] sb;
        logic signed [15:0] cb;
        logic signed [15:0] sc;
        logic signed [15:0] cc;
        logic        [7:0]  cam;
        logic signed [6:0]  shift;
    } cfg_t;

    typedef struct packed {
        logic              hit;
        logic [CELL_W-1:0] cell_idx;
        logic [15:0]       ooz;
    } geom_res_t;

    function automatic logic signed [63:0] trunc_pow2(input logic signed [63:0] v,
                                                      input int sh);
        logic signed [63:0] q;
        logic [63:0]        mask;
        q    = v >>> sh;
        mask = (64'd1 << sh) - 64'd1;
        if (v[63] && ((v & mask) != 64'd0)) begin
            q = q + 64'sd1;
        end
        return q;
    endfunction

endpackage

/* sv/prpz_geom.sv */
// Rotation, reciprocal depth and projection sequencer around one shared signed multiplier
// and a bit-serial divider. Depends on prpz_pkg.
module prpz_geom (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  prpz_pkg::cfg_t      cfg,
    input  logic signed [6:0]   point_x,
    input  logic signed [6:0]   point_y,
    input  logic signed [6:0]   point_z,
    output logic                done,
    output prpz_pkg::geom_res_t res
);

    localparam logic [3:0] G_IDLE = 4'd0;
    localparam logic [3:0] G_ROT  = 4'd1;
    localparam logic [3:0] G_ZCHK = 4'd2;
    localparam logic [3:0] G_DIV  = 4'd3;
    localparam logic [3:0] G_PX   = 4'd4;
    localparam logic [3:0] G_PY   = 4'd5;
    localparam logic [3:0] G_PS   = 4'd6;
    localparam logic [3:0] G_IDX  = 4'd7;
    localparam logic [3:0] G_DONE = 4'd8;

    localparam logic [2:0] D_U = 3'd0;
    localparam logic [2:0] D_V = 3'd1;
    localparam logic [2:0] D_W = 3'd2;
    localparam logic [2:0] D_T = 3'd3;
    localparam logic [2:0] D_X = 3'd4;
    localparam logic [2:0] D_Y = 3'd5;
    localparam logic [2:0] D_Z = 3'd6;

    localparam int ROT_STEPS = 16;
    localparam int SCALE2_W  = $clog2(2 * prpz_pkg::PROJECTION_SCALE + 1);
    localparam logic [SCALE2_W-1:0] SCALE_X = SCALE2_W'(2 * prpz_pkg::PROJECTION_SCALE);
    localparam logic [SCALE2_W-1:0] SCALE_Y = SCALE2_W'(prpz_pkg::PROJECTION_SCALE);
    localparam int OOZK_W    = 16 + SCALE2_W;
    localparam int MB_W      = OOZK_W + 1;
    localparam int MA_W      = 28;
    localparam int P_W       = MA_W + MB_W;

    logic [3:0]                state_reg, state_next;
    logic [4:0]                step_reg;
    logic signed [6:0]         pi_reg, pj_reg, pk_reg;
    logic signed [23:0]        u_reg, v_reg;
    logic signed [39:0]        w_reg;
    logic signed [22:0]        t_reg;
    logic signed [63:0]        x_reg, y_reg, z_reg;
    logic signed [P_W-1:0]     p_reg, colp_reg;
    logic                      acc_vld_reg;
    logic [2:0]                acc_dst_reg;
    logic [4:0]                acc_sh_reg;
    logic                      acc_neg_reg;
    logic [63:0]               rem_reg;
    logic [15:0]               q_reg;
    logic [3:0]                bit_reg;
    logic [15:0]               ooz_reg;
    logic signed [27:0]        xp_reg, yp_reg;
    logic                      hit_reg;
    logic [prpz_pkg::CELL_W-1:0] cell_reg;

    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic [2:0]                rot_dst;
    logic [4:0]                rot_sh;
    logic                      rot_neg;
    logic signed [63:0]        acc_val;
    logic signed [63:0]        x14, y14, colq, rowq;
    logic [OOZK_W-1:0]         ooz_x, ooz_y;
    logic [63:0]               rem_sh;
    logic signed [35:0]        idx;

    always_comb begin
        rot_dst = D_U;
        rot_sh  = 5'd0;
        rot_neg = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        x14     = prpz_pkg::trunc_pow2(x_reg, 28);
        y14     = prpz_pkg::trunc_pow2(y_reg, 28);
        ooz_x   = OOZK_W'(ooz_reg * SCALE_X);
        ooz_y   = OOZK_W'(ooz_reg * SCALE_Y);
        if (state_reg == G_ROT) begin
            case (step_reg)
                5'd0:  begin mul_a = MA_W'(pj_reg); mul_b = MB_W'(cfg.sa); end
                5'd1:  begin mul_a = MA_W'(pk_reg); mul_b = MB_W'(cfg.ca); rot_neg = 1'b1; end
                5'd2:  begin mul_a = MA_W'(pj_reg); mul_b = MB_W'(cfg.ca); rot_dst = D_V; end
                5'd3:  begin mul_a = MA_W'(pk_reg); mul_b = MB_W'(cfg.sa); rot_dst = D_V; end
                5'd4:  begin mul_a = MA_W'(u_reg);  mul_b = MB_W'(cfg.sb); rot_dst = D_W; end
                5'd5:  begin
                    mul_a = MA_W'(u_reg); mul_b = MB_W'(cfg.cb);
                    rot_dst = D_Z; rot_sh = 5'd14; rot_neg = 1'b1;
                end
                5'd6:  begin
                    mul_a = MA_W'(pi_reg); mul_b = MB_W'(cfg.sb);
                    rot_dst = D_Z; rot_sh = 5'd28;
                end
                5'd7:  begin mul_a = MA_W'(pi_reg); mul_b = MB_W'(cfg.cb); rot_dst = D_T; end
                5'd8:  begin
                    mul_a = MA_W'(v_reg); mul_b = MB_W'(cfg.sc); rot_dst = D_X; rot_sh = 5'd14;
                end
                5'd9:  begin
                    mul_a = MA_W'(v_reg); mul_b = MB_W'(cfg.cc); rot_dst = D_Y; rot_sh = 5'd14;
                end
                5'd10: begin
                    mul_a = {8'd0, w_reg[19:0]}; mul_b = MB_W'(cfg.cc); rot_dst = D_X;
                end
                5'd11: begin
                    mul_a = MA_W'(signed'(w_reg[39:20])); mul_b = MB_W'(cfg.cc);
                    rot_dst = D_X; rot_sh = 5'd20;
                end
                5'd12: begin
                    mul_a = {8'd0, w_reg[19:0]}; mul_b = MB_W'(cfg.sc);
                    rot_dst = D_Y; rot_neg = 1'b1;
                end
                5'd13: begin
                    mul_a = MA_W'(signed'(w_reg[39:20])); mul_b = MB_W'(cfg.sc);
                    rot_dst = D_Y; rot_sh = 5'd20; rot_neg = 1'b1;
                end
                5'd14: begin
                    mul_a = MA_W'(t_reg); mul_b = MB_W'(cfg.cc); rot_dst = D_X; rot_sh = 5'd14;
                end
                5'd15: begin
                    mul_a = MA_W'(t_reg); mul_b = MB_W'(cfg.sc);
                    rot_dst = D_Y; rot_sh = 5'd14; rot_neg = 1'b1;
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end else if (state_reg == G_PX) begin
            mul_a = MA_W'(x14);
            mul_b = MB_W'({1'b0, ooz_x});
        end else if (state_reg == G_PY) begin
            mul_a = MA_W'(y14);
            mul_b = MB_W'({1'b0, ooz_y});
        end
    end

    always_comb begin
        acc_val = 64'(p_reg) <<< acc_sh_reg;
        if (acc_neg_reg) begin
            acc_val = -acc_val;
        end
        colq = (64'(signed'(32'(prpz_pkg::HALF_W))) + 64'(cfg.shift)) * (64'sd1 <<< 30)
             + 64'(colp_reg);
        rowq = 64'(signed'(32'(prpz_pkg::HALF_H))) * (64'sd1 <<< 30) + 64'(p_reg);
        rem_sh = {rem_reg[62:0], 1'b0};
        idx = 36'(xp_reg) + 36'(yp_reg) * 36'(prpz_pkg::SCREEN_WIDTH);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            G_IDLE: if (start) state_next = G_ROT;
            G_ROT:  if (step_reg == 5'(ROT_STEPS)) state_next = G_ZCHK;
            G_ZCHK: begin
                if (z_reg <= 64'sd0) begin
                    state_next = G_DONE;
                end else if (z_reg <= (64'sd1 <<< 42)) begin
                    state_next = G_PX;
                end else begin
                    state_next = G_DIV;
                end
            end
            G_DIV:  if (bit_reg == 4'd0) state_next = G_PX;
            G_PX:   state_next = G_PY;
            G_PY:   state_next = G_PS;
            G_PS:   state_next = G_IDX;
            G_IDX:  state_next = G_DONE;
            G_DONE: state_next = G_IDLE;
            default: state_next = G_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= G_IDLE;
            acc_vld_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            acc_vld_reg <= (state_reg == G_ROT) && (step_reg < 5'(ROT_STEPS));
            if (state_reg == G_ROT) begin
                step_reg <= step_reg + 5'd1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_reg       <= P_W'(mul_a * mul_b);
        acc_dst_reg <= rot_dst;
        acc_sh_reg  <= rot_sh;
        acc_neg_reg <= rot_neg;
        if (start && state_reg == G_IDLE) begin
            pi_reg <= point_x;
            pj_reg <= point_y;
            pk_reg <= point_z;
            u_reg  <= '0;
            v_reg  <= '0;
            w_reg  <= '0;
            t_reg  <= '0;
            x_reg  <= '0;
            y_reg  <= '0;
            z_reg  <= 64'(cfg.cam) <<< 42;
        end else if (acc_vld_reg) begin
            case (acc_dst_reg)
                D_U:     u_reg <= u_reg + acc_val[23:0];
                D_V:     v_reg <= v_reg + acc_val[23:0];
                D_W:     w_reg <= w_reg + acc_val[39:0];
                D_T:     t_reg <= t_reg + acc_val[22:0];
                D_X:     x_reg <= x_reg + acc_val;
                D_Y:     y_reg <= y_reg + acc_val;
                D_Z:     z_reg <= z_reg + acc_val;
                default: u_reg <= u_reg;
            endcase
        end
        if (state_reg == G_ZCHK) begin
            hit_reg <= 1'b0;
            ooz_reg <= 16'hFFFF;
            rem_reg <= 64'd1 << 42;
            q_reg   <= '0;
            bit_reg <= 4'd15;
        end
        if (state_reg == G_DIV) begin
            if (rem_sh >= 64'(z_reg)) begin
                rem_reg <= rem_sh - 64'(z_reg);
                q_reg   <= {q_reg[14:0], 1'b1};
                ooz_reg <= {q_reg[14:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[14:0], 1'b0};
                ooz_reg <= {q_reg[14:0], 1'b0};
            end
            bit_reg <= bit_reg - 4'd1;
        end
        if (state_reg == G_PY) begin
            colp_reg <= p_reg;
        end
        if (state_reg == G_PS) begin
            xp_reg <= 28'(prpz_pkg::trunc_pow2(colq, 30));
            yp_reg <= 28'(prpz_pkg::trunc_pow2(rowq, 30));
        end
        if (state_reg == G_IDX) begin
            hit_reg  <= (idx >= 36'sd0) && (idx < 36'(prpz_pkg::CELLS));
            cell_reg <= idx[prpz_pkg::CELL_W-1:0];
        end
    end

    assign done         = (state_reg == G_DONE);
    assign res.hit      = hit_reg;
    assign res.cell_idx = cell_reg;
    assign res.ooz      = ooz_reg;

endmodule

/* sv/point_rotate_project_zbuffer.sv */
// Plot items pass through rotation (on the one shared 28x24 multiplier), a depth check, a
// bit-serial reciprocal, projection and indexing, then one memory read of the cell and a write
// when the new point is nearer. The divide is skipped when the reciprocal saturates; a depth at
// or below zero or an off-screen cell gives an unplotted result. Read-and-clear items read and
// clear the cell or, for an index beyond the screen, skip the memory and return a space glyph.
// The next item can be accepted in the cycle after the result is loaded; m_tready held low
// while a result is pending stalls the result stage and the input with it. After reset the
// block sweeps all 5000 cells with s_tready low; configuration writes are taken meanwhile.
module point_rotate_project_zbuffer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // point_x, point_y, point_z, glyph, cell_index, zero pad
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // screen_cell, cell_glyph, zero pad
    output logic        m_tuser    // plotted
);

    localparam int CW = prpz_pkg::CELL_W;

    localparam logic [2:0] T_CLEAR = 3'd0;
    localparam logic [2:0] T_IDLE  = 3'd1;
    localparam logic [2:0] T_GEOM  = 3'd2;
    localparam logic [2:0] T_READ  = 3'd3;
    localparam logic [2:0] T_MOD   = 3'd4;
    localparam logic [2:0] T_OUT   = 3'd5;

    logic [2:0]          state_reg;
    logic [CW-1:0]       clr_cnt_reg;
    prpz_pkg::cfg_t      cfg_reg;
    logic                cmd_reg;
    logic [7:0]          glyph_reg;
    logic [15:0]         ooz_reg;
    logic [CW-1:0]       addr_reg;
    logic                res_plot_reg;
    logic [CW-1:0]       res_cell_reg;
    logic [7:0]          res_glyph_reg;
    logic                m_tvalid_reg;
    logic                m_plot_reg;
    logic [CW-1:0]       m_cell_reg;
    logic [7:0]          m_glyph_reg;
    logic [23:0]         mem [prpz_pkg::CELLS];
    logic [23:0]         rd_data_reg;

    logic                s_acc;
    logic                geom_done;
    prpz_pkg::geom_res_t geom_res;
    logic                mem_we;
    logic [CW-1:0]       mem_wa;
    logic [23:0]         mem_wd;
    logic                nearer;
    logic [CW-1:0]       in_cell;
    logic                out_load;

    assign s_tready = (state_reg == T_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_cell  = s_tdata[41:29];
    assign nearer   = ooz_reg > rd_data_reg[23:8];
    assign out_load = (state_reg == T_OUT) && (!m_tvalid_reg || m_tready);

    prpz_geom u_geom (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_acc && (s_tuser == prpz_pkg::CMD_PLOT)),
        .cfg     (cfg_reg),
        .point_x (signed'(s_tdata[6:0])),
        .point_y (signed'(s_tdata[13:7])),
        .point_z (signed'(s_tdata[20:14])),
        .done    (geom_done),
        .res     (geom_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sa    <= '0;
            cfg_reg.ca    <= 16'sd16384;
            cfg_reg.sb    <= '0;
            cfg_reg.cb    <= 16'sd16384;
            cfg_reg.sc    <= '0;
            cfg_reg.cc    <= 16'sd16384;
            cfg_reg.cam   <= 8'd50;
            cfg_reg.shift <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                prpz_pkg::REG_SIN_A: cfg_reg.sa    <= signed'(cfg_data);
                prpz_pkg::REG_COS_A: cfg_reg.ca    <= signed'(cfg_data);
                prpz_pkg::REG_SIN_B: cfg_reg.sb    <= signed'(cfg_data);
                prpz_pkg::REG_COS_B: cfg_reg.cb    <= signed'(cfg_data);
                prpz_pkg::REG_SIN_C: cfg_reg.sc    <= signed'(cfg_data);
                prpz_pkg::REG_COS_C: cfg_reg.cc    <= signed'(cfg_data);
                prpz_pkg::REG_CAM:   cfg_reg.cam   <= cfg_data[7:0];
                prpz_pkg::REG_SHIFT: cfg_reg.shift <= signed'(cfg_data[6:0]);
                default:             cfg_reg.cam   <= cfg_reg.cam;
            endcase
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = {16'd0, prpz_pkg::SPACE_GLYPH};
        if (state_reg == T_CLEAR) begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
        end else if (state_reg == T_MOD) begin
            if (cmd_reg == prpz_pkg::CMD_READ) begin
                mem_we = 1'b1;
            end else if (nearer) begin
                mem_we = 1'b1;
                mem_wd = {ooz_reg, glyph_reg};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CW'(prpz_pkg::CELLS - 1)) begin
                        state_reg <= T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (s_acc) begin
                        cmd_reg   <= s_tuser;
                        glyph_reg <= s_tdata[28:21];
                        addr_reg  <= in_cell;
                        if (s_tuser == prpz_pkg::CMD_PLOT) begin
                            state_reg <= T_GEOM;
                        end else if (in_cell < CW'(prpz_pkg::CELLS)) begin
                            state_reg <= T_READ;
                        end else begin
                            res_plot_reg  <= 1'b0;
                            res_cell_reg  <= in_cell;
                            res_glyph_reg <= prpz_pkg::SPACE_GLYPH;
                            state_reg     <= T_OUT;
                        end
                    end
                end
                T_GEOM: begin
                    if (geom_done) begin
                        ooz_reg  <= geom_res.ooz;
                        addr_reg <= geom_res.cell_idx;
                        if (geom_res.hit) begin
                            state_reg <= T_READ;
                        end else begin
                            res_plot_reg  <= 1'b0;
                            res_cell_reg  <= '0;
                            res_glyph_reg <= '0;
                            state_reg     <= T_OUT;
                        end
                    end
                end
                T_READ: state_reg <= T_MOD;
                T_MOD: begin
                    if (cmd_reg == prpz_pkg::CMD_READ) begin
                        res_plot_reg  <= 1'b0;
                        res_cell_reg  <= addr_reg;
                        res_glyph_reg <= rd_data_reg[7:0];
                    end else begin
                        res_plot_reg  <= nearer;
                        res_cell_reg  <= nearer ? addr_reg : '0;
                        res_glyph_reg <= '0;
                    end
                    state_reg <= T_OUT;
                end
                T_OUT: begin
                    if (out_load) begin
                        m_plot_reg   <= res_plot_reg;
                        m_cell_reg   <= res_cell_reg;
                        m_glyph_reg  <= res_glyph_reg;
                        state_reg    <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_plot_reg;
    assign m_tdata  = {3'd0, m_glyph_reg, m_cell_reg};

endmodule
